[design/bqc_pkg.sv]
// shared constants, types and helpers of the two-section biquad filter core
package bqc_pkg;

	// default parameter values
	localparam int DEFAULT_SAMPLE_BITS    = 16;
	localparam int DEFAULT_COEF_FRAC_BITS = 14;

	// fixed widths of the arithmetic
	localparam int COEF_BITS   = 17;
	localparam int STATE_BITS  = 32;
	localparam int PROD_BITS   = COEF_BITS + STATE_BITS;
	localparam int ACC_BITS    = 52;
	localparam int NUM_BITS    = 3 * COEF_BITS;
	localparam int DEN_BITS    = 2 * COEF_BITS;

	// configuration port
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = NUM_BITS;

	localparam logic [CFG_IDX_BITS-1:0] REG_ENABLE = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_NUM1   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_DEN1   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_NUM2   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_DEN2   = 3'd4;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MB0,
		ST_MB1,
		ST_MB2,
		ST_MA1,
		ST_MA2,
		ST_FIN,
		ST_DONE
	} state_t;

	// coefficient picked for the shared multiplier
	typedef enum logic [2:0] {
		COEF_B0,
		COEF_B1,
		COEF_B2,
		COEF_A1,
		COEF_A2
	} coef_sel_t;

	// accumulate step applied to the registered product
	typedef enum logic [2:0] {
		ACC_NONE,
		ACC_LOAD_P,
		ACC_LOAD_A0,
		ACC_LOAD_A1,
		ACC_SUB_A0,
		ACC_FINISH
	} acc_op_t;

	// controller to datapath commands
	typedef struct packed {
		logic      load_x;
		logic      opnd_p;
		coef_sel_t coef_sel;
		acc_op_t   acc_op;
		logic      sect;
		logic      bypass;
		logic      out_load;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic enable;
	} status_t;

	// saturated state word and its clip flag
	typedef struct packed {
		logic                         clip;
		logic signed [STATE_BITS-1:0] value;
	} sat_t;

	// saturate an accumulator value to a signed state word
	function automatic sat_t sat_state(input logic signed [ACC_BITS-1:0] v);
		sat_t r;
		logic [ACC_BITS-STATE_BITS:0] top;
		top = v[ACC_BITS-1:STATE_BITS-1];
		if ((top == '0) || (top == '1)) begin
			r.clip  = 1'b0;
			r.value = v[STATE_BITS-1:0];
		end else begin
			r.clip  = 1'b1;
			r.value = v[ACC_BITS-1] ? {1'b1, {(STATE_BITS-1){1'b0}}}
			                        : {1'b0, {(STATE_BITS-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

[design/bqc_in_if.sv]
// sample request channel into the filter
interface bqc_in_if #(
	parameter int SAMPLE_BITS = bqc_pkg::DEFAULT_SAMPLE_BITS
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

[design/bqc_out_if.sv]
// result request channel out of the filter
interface bqc_out_if #(
	parameter int SAMPLE_BITS = bqc_pkg::DEFAULT_SAMPLE_BITS
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          clipped;

	modport source (output valid, output sample_out, output clipped, input ready);
	modport sink (input valid, input sample_out, input clipped, output ready);
endinterface

[design/bqc_ctrl.sv]
// sequencer that steps the shared multiplier through both sections
module bqc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  bqc_pkg::status_t status,
	output bqc_pkg::cmd_t    cmd
);

	bqc_pkg::state_t state_q, state_d;
	logic            sect_q, sect_d;
	logic            bypass_q, bypass_d;
	logic            out_valid_q;

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bqc_pkg::ST_IDLE;
			sect_q      <= 1'b0;
			bypass_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			sect_q   <= sect_d;
			bypass_q <= bypass_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// next state and commands
	always_comb begin
		state_d      = state_q;
		sect_d       = sect_q;
		bypass_d     = bypass_q;
		in_ready     = 1'b0;
		cmd.load_x   = 1'b0;
		cmd.opnd_p   = 1'b0;
		cmd.coef_sel = bqc_pkg::COEF_B0;
		cmd.acc_op   = bqc_pkg::ACC_NONE;
		cmd.sect     = sect_q;
		cmd.bypass   = bypass_q;
		cmd.out_load = 1'b0;
		case (state_q)
			bqc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_x = 1'b1;
					sect_d     = 1'b0;
					bypass_d   = !status.enable;
					state_d    = status.enable ? bqc_pkg::ST_MB0 : bqc_pkg::ST_DONE;
				end
			end
			bqc_pkg::ST_MB0: begin
				cmd.coef_sel = bqc_pkg::COEF_B0;
				state_d      = bqc_pkg::ST_MB1;
			end
			bqc_pkg::ST_MB1: begin
				cmd.coef_sel = bqc_pkg::COEF_B1;
				cmd.acc_op   = bqc_pkg::ACC_LOAD_P;
				state_d      = bqc_pkg::ST_MB2;
			end
			bqc_pkg::ST_MB2: begin
				cmd.coef_sel = bqc_pkg::COEF_B2;
				cmd.acc_op   = bqc_pkg::ACC_LOAD_A0;
				state_d      = bqc_pkg::ST_MA1;
			end
			bqc_pkg::ST_MA1: begin
				cmd.coef_sel = bqc_pkg::COEF_A1;
				cmd.opnd_p   = 1'b1;
				cmd.acc_op   = bqc_pkg::ACC_LOAD_A1;
				state_d      = bqc_pkg::ST_MA2;
			end
			bqc_pkg::ST_MA2: begin
				cmd.coef_sel = bqc_pkg::COEF_A2;
				cmd.opnd_p   = 1'b1;
				cmd.acc_op   = bqc_pkg::ACC_SUB_A0;
				state_d      = bqc_pkg::ST_FIN;
			end
			bqc_pkg::ST_FIN: begin
				cmd.acc_op = bqc_pkg::ACC_FINISH;
				if (!sect_q) begin
					sect_d  = 1'b1;
					state_d = bqc_pkg::ST_MB0;
				end else begin
					state_d = bqc_pkg::ST_DONE;
				end
			end
			bqc_pkg::ST_DONE: begin
				// wait for a free output register
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = bqc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bqc_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

[design/bqc_datapath.sv]
// coefficient registers, shared multiplier, accumulators and delay words
module bqc_datapath #(
	parameter int SAMPLE_BITS    = bqc_pkg::DEFAULT_SAMPLE_BITS,
	parameter int COEF_FRAC_BITS = bqc_pkg::DEFAULT_COEF_FRAC_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [bqc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [bqc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  logic signed [SAMPLE_BITS-1:0]        sample_in,
	input  bqc_pkg::cmd_t                        cmd,
	output bqc_pkg::status_t                     status,
	output logic signed [SAMPLE_BITS-1:0]        sample_out,
	output logic                                 clipped
);

	localparam int SB = bqc_pkg::STATE_BITS;
	localparam int PB = bqc_pkg::PROD_BITS;
	localparam int AB = bqc_pkg::ACC_BITS;
	localparam int CB = bqc_pkg::COEF_BITS;

	localparam logic signed [PB-1:0] RND_HALF = PB'(1) << (COEF_FRAC_BITS - 1);
	localparam logic signed [SB-1:0] OUT_MAX  = (SB'(1) << (SAMPLE_BITS - 1)) - SB'(1);
	localparam logic signed [SB-1:0] OUT_MIN  = -OUT_MAX - SB'(1);

	// configuration registers
	logic                         enable_q;
	logic [bqc_pkg::NUM_BITS-1:0] num1_q, num2_q;
	logic [bqc_pkg::DEN_BITS-1:0] den1_q, den2_q;

	// delay words of both sections
	logic signed [SB-1:0] s1_d0_q, s1_d1_q, s2_d0_q, s2_d1_q;

	// working registers
	logic signed [SB-1:0] x_q, p_q;
	logic signed [PB-1:0] prod_q;
	logic signed [AB-1:0] acc0_q, acc1_q;
	logic                 clip_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;
	logic                          clipped_q;

	logic [bqc_pkg::NUM_BITS-1:0] num_sel;
	logic [bqc_pkg::DEN_BITS-1:0] den_sel;
	logic signed [CB-1:0]         coef_v;
	logic signed [SB-1:0]         opnd_v;
	logic signed [PB-1:0]         prod_full, prod_rnd;
	logic signed [SB-1:0]         d0_cur, d1_cur;
	logic signed [AB-1:0]         prod_ext;
	bqc_pkg::sat_t                p_sat, n0_sat, n1_sat;
	logic signed [SB-1:0]         y_sat;
	logic                         y_clip;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			num1_q   <= '0;
			den1_q   <= '0;
			num2_q   <= '0;
			den2_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				bqc_pkg::REG_ENABLE: enable_q <= cfg_data[0];
				bqc_pkg::REG_NUM1:   num1_q   <= cfg_data[bqc_pkg::NUM_BITS-1:0];
				bqc_pkg::REG_DEN1:   den1_q   <= cfg_data[bqc_pkg::DEN_BITS-1:0];
				bqc_pkg::REG_NUM2:   num2_q   <= cfg_data[bqc_pkg::NUM_BITS-1:0];
				bqc_pkg::REG_DEN2:   den2_q   <= cfg_data[bqc_pkg::DEN_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	assign status.enable = enable_q;

	// coefficient and operand selection
	assign num_sel = cmd.sect ? num2_q : num1_q;
	assign den_sel = cmd.sect ? den2_q : den1_q;

	always_comb begin
		case (cmd.coef_sel)
			bqc_pkg::COEF_B0: coef_v = num_sel[CB-1:0];
			bqc_pkg::COEF_B1: coef_v = num_sel[2*CB-1:CB];
			bqc_pkg::COEF_B2: coef_v = num_sel[3*CB-1:2*CB];
			bqc_pkg::COEF_A1: coef_v = den_sel[CB-1:0];
			bqc_pkg::COEF_A2: coef_v = den_sel[2*CB-1:CB];
			default:          coef_v = '0;
		endcase
	end

	assign opnd_v = cmd.opnd_p ? p_q : x_q;

	// shared multiplier with round half up
	assign prod_full = PB'(coef_v) * PB'(opnd_v);
	assign prod_rnd  = prod_full + RND_HALF;

	// accumulate on the registered product
	assign d0_cur   = cmd.sect ? s2_d0_q : s1_d0_q;
	assign d1_cur   = cmd.sect ? s2_d1_q : s1_d1_q;
	assign prod_ext = AB'(prod_q);
	assign p_sat    = bqc_pkg::sat_state(prod_ext + AB'(d0_cur));
	assign n0_sat   = bqc_pkg::sat_state(acc0_q);
	assign n1_sat   = bqc_pkg::sat_state(acc1_q - prod_ext);

	// final saturation to the sample width
	always_comb begin
		if (p_q > OUT_MAX) begin
			y_sat  = OUT_MAX;
			y_clip = 1'b1;
		end else if (p_q < OUT_MIN) begin
			y_sat  = OUT_MIN;
			y_clip = 1'b1;
		end else begin
			y_sat  = p_q;
			y_clip = 1'b0;
		end
	end

	// delay words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_d0_q <= '0;
			s1_d1_q <= '0;
			s2_d0_q <= '0;
			s2_d1_q <= '0;
		end else if (cmd.acc_op == bqc_pkg::ACC_FINISH) begin
			if (cmd.sect) begin
				s2_d0_q <= n0_sat.value;
				s2_d1_q <= n1_sat.value;
			end else begin
				s1_d0_q <= n0_sat.value;
				s1_d1_q <= n1_sat.value;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		prod_q <= prod_rnd >>> COEF_FRAC_BITS;
		if (cmd.load_x) begin
			x_q    <= SB'(sample_in);
			clip_q <= 1'b0;
		end
		case (cmd.acc_op)
			bqc_pkg::ACC_LOAD_P: begin
				p_q    <= p_sat.value;
				clip_q <= clip_q | p_sat.clip;
			end
			bqc_pkg::ACC_LOAD_A0: acc0_q <= prod_ext + AB'(d1_cur);
			bqc_pkg::ACC_LOAD_A1: acc1_q <= prod_ext;
			bqc_pkg::ACC_SUB_A0:  acc0_q <= acc0_q - prod_ext;
			bqc_pkg::ACC_FINISH: begin
				x_q    <= p_q;
				clip_q <= clip_q | n0_sat.clip | n1_sat.clip;
			end
			default: begin
			end
		endcase
		if (cmd.out_load) begin
			if (cmd.bypass) begin
				sample_out_q <= x_q[SAMPLE_BITS-1:0];
				clipped_q    <= 1'b0;
			end else begin
				sample_out_q <= y_sat[SAMPLE_BITS-1:0];
				clipped_q    <= clip_q | y_clip;
			end
		end
	end

	assign sample_out = sample_out_q;
	assign clipped    = clipped_q;

endmodule

[design/biquad_cascade_iir_filter_core.sv]
// top level of the two-section biquad filter core
// each sample takes ten product steps on the single shared 17x32 multiplier, two
// write-back steps, one hand-off and one accept step (only the last two in bypass);
// a new sample is taken only after the hand-off, which waits for a free output register
// a finished result waits in the output register while the next sample is taken
// reset: asynchronous, clears the sequencer, configuration and all delay words
module biquad_cascade_iir_filter_core #(
	parameter int SAMPLE_BITS    = bqc_pkg::DEFAULT_SAMPLE_BITS,
	parameter int COEF_FRAC_BITS = bqc_pkg::DEFAULT_COEF_FRAC_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	bqc_in_if.sink                            in_ch,
	bqc_out_if.source                         out_ch,
	input  logic                              cfg_we,
	input  logic [bqc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [bqc_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	bqc_pkg::cmd_t    cmd;
	bqc_pkg::status_t status;

	// sequencer
	bqc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// arithmetic and storage
	bqc_datapath #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample_in  (in_ch.sample_in),
		.cmd        (cmd),
		.status     (status),
		.sample_out (out_ch.sample_out),
		.clipped    (out_ch.clipped)
	);

endmodule

[verif/testbench.sv]
// testbench for the two-section biquad filter core: directed table, random phases, checker
`timescale 1ns / 1ps

module testbench;

	localparam int SAMPLE_BITS = bqc_pkg::DEFAULT_SAMPLE_BITS;
	localparam int FRAC_BITS   = bqc_pkg::DEFAULT_COEF_FRAC_BITS;
	localparam int CB          = bqc_pkg::COEF_BITS;
	localparam int IDX_BITS    = bqc_pkg::CFG_IDX_BITS;
	localparam int DATA_BITS   = bqc_pkg::CFG_DATA_BITS;
	localparam int NB          = bqc_pkg::NUM_BITS;
	localparam int DB          = bqc_pkg::DEN_BITS;
	localparam int UNITY       = 1 << FRAC_BITS;
	localparam int COEF_MAX    = (1 << (CB - 1)) - 1;
	localparam int COEF_MIN    = -(1 << (CB - 1));
	localparam int SETTLE_CYCLES = 20;
	localparam int DRAIN_CYCLES  = 30;
	localparam int LONG_HOLD     = 400;
	localparam int ITEMS_PER_PHASE = 125;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int MAX_REPORTS   = 50;

	// index with no register behind it
	localparam logic [IDX_BITS-1:0] REG_VOID = 3'd7;

	typedef enum {ROW_WRITE, ROW_SAMPLE} row_kind_t;
	typedef enum {STYLE_STABLE, STYLE_WILD, STYLE_EXTREME, STYLE_BYPASS} coef_style_t;
	typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_MOSTLY} ready_mode_t;

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          clipped;
	} filt_result_t;

	typedef struct {
		row_kind_t                     kind;
		logic [IDX_BITS-1:0]           idx;
		logic [DATA_BITS-1:0]          data;
		logic signed [SAMPLE_BITS-1:0] sample;
		bit                            typed;
		filt_result_t                  want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [IDX_BITS-1:0] cfg_index;
	logic [DATA_BITS-1:0] cfg_data;

	bqc_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) smp_ch ();
	bqc_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) res_ch ();

	biquad_cascade_iir_filter_core #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COEF_FRAC_BITS(FRAC_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(smp_ch),
		.out_ch(res_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// shadow configuration and delay words of the filter
	bit filt_on;
	logic [NB-1:0] num1, num2;
	logic [DB-1:0] den1, den2;
	longint stage1_dly[2];
	longint stage2_dly[2];

	stim_row_t offered_q[$];
	filt_result_t expected_q[$];

	int mismatches;
	int samples_taken;
	int results_checked;
	int clipped_seen;
	int settings_used;
	int burst_left;
	int hold_requests;
	int cycle_count;

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// coefficient times value, rounded back with halves going up
	function automatic longint round_product(input longint c, input longint v);
		return (c * v + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
	endfunction

	function automatic longint clamp(input longint v, input int bits, inout bit clip);
		longint hi, lo;
		hi = (longint'(1) << (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			clip = 1'b1;
			return hi;
		end
		if (v < lo) begin
			clip = 1'b1;
			return lo;
		end
		return v;
	endfunction

	// one transposed direct form II section
	function automatic longint run_section(input longint x, input logic [NB-1:0] num,
			input logic [DB-1:0] den, inout longint d0, inout longint d1, inout bit clip);
		logic signed [CB-1:0] b0, b1, b2, a1, a2;
		longint p;
		b0 = num[CB-1:0];
		b1 = num[2*CB-1:CB];
		b2 = num[3*CB-1:2*CB];
		a1 = den[CB-1:0];
		a2 = den[2*CB-1:CB];
		p = clamp(round_product(b0, x) + d0, bqc_pkg::STATE_BITS, clip);
		d0 = clamp(round_product(b1, x) - round_product(a1, p) + d1, bqc_pkg::STATE_BITS, clip);
		d1 = clamp(round_product(b2, x) - round_product(a2, p), bqc_pkg::STATE_BITS, clip);
		return p;
	endfunction

	// predicted output of the cascade for one sample, advancing the delay words
	function automatic filt_result_t filter_sample(input logic signed [SAMPLE_BITS-1:0] s);
		filt_result_t r;
		longint y;
		bit clip;
		clip = 1'b0;
		if (!filt_on) begin
			r.sample  = s;
			r.clipped = 1'b0;
			return r;
		end
		y = run_section(s, num1, den1, stage1_dly[0], stage1_dly[1], clip);
		y = run_section(y, num2, den2, stage2_dly[0], stage2_dly[1], clip);
		y = clamp(y, SAMPLE_BITS, clip);
		r.sample  = y[SAMPLE_BITS-1:0];
		r.clipped = clip;
		return r;
	endfunction

	function automatic logic [DATA_BITS-1:0] pack_num(input int b0, input int b1, input int b2);
		return {b2[CB-1:0], b1[CB-1:0], b0[CB-1:0]};
	endfunction

	function automatic logic [DATA_BITS-1:0] pack_den(input int a1, input int a2);
		return {{(DATA_BITS-DB){1'b0}}, a2[CB-1:0], a1[CB-1:0]};
	endfunction

	function automatic int extreme_coef();
		case ($urandom_range(0, 2))
			0: return COEF_MIN;
			1: return COEF_MAX;
			default: return 0;
		endcase
	endfunction

	function automatic stim_row_t reg_row(input logic [IDX_BITS-1:0] idx,
			input logic [DATA_BITS-1:0] data);
		stim_row_t r;
		r.kind         = ROW_WRITE;
		r.idx          = idx;
		r.data         = data;
		r.sample       = '0;
		r.typed        = 1'b0;
		r.want.sample  = '0;
		r.want.clipped = 1'b0;
		return r;
	endfunction

	function automatic stim_row_t sample_row(input logic signed [SAMPLE_BITS-1:0] s,
			input bit typed = 1'b0, input logic signed [SAMPLE_BITS-1:0] want = '0,
			input logic want_clip = 1'b0);
		stim_row_t r;
		r.kind           = ROW_SAMPLE;
		r.idx            = '0;
		r.data           = '0;
		r.sample         = s;
		r.typed          = typed;
		r.want.sample    = want;
		r.want.clipped   = want_clip;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("result %0d: %s is %0d, expected %0d", results_checked, what, got, want);
	endtask

	// register write once the filter has gone quiet
	task automatic write_reg(input logic [IDX_BITS-1:0] idx,
			input logic [DATA_BITS-1:0] data);
		smp_ch.valid <= 1'b0;
		while (offered_q.size() + expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			bqc_pkg::REG_ENABLE: filt_on = data[0];
			bqc_pkg::REG_NUM1:   num1 = data[NB-1:0];
			bqc_pkg::REG_DEN1:   den1 = data[DB-1:0];
			bqc_pkg::REG_NUM2:   num2 = data[NB-1:0];
			bqc_pkg::REG_DEN2:   den2 = data[DB-1:0];
			default: ;
		endcase
	endtask

	// offer one sample request in bursts with random gaps, return at acceptance
	task automatic offer_row(input stim_row_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
			if (gap != 0) begin
				smp_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		offered_q.push_back(r);
		smp_ch.valid     <= 1'b1;
		smp_ch.sample_in <= r.sample;
		@(posedge clk);
		while (!smp_ch.ready)
			@(posedge clk);
	endtask

	// accepted sample request: predict and queue its result
	always @(posedge clk) begin : take_sample
		stim_row_t row;
		filt_result_t predicted;
		if (arst_n && smp_ch.valid && smp_ch.ready) begin
			predicted = filter_sample(smp_ch.sample_in);
			row = offered_q.pop_front();
			if (row.typed)
				expected_q.push_back(row.want);
			else
				expected_q.push_back(predicted);
			samples_taken++;
		end
	end

	// accepted result request: compare with the oldest expectation
	always @(posedge clk) begin : check_result
		filt_result_t due;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unrequested result, sample_out", res_ch.sample_out, 0);
			end else begin
				due = expected_q.pop_front();
				if (res_ch.sample_out !== due.sample)
					report_mismatch("sample_out", res_ch.sample_out, due.sample);
				if (res_ch.clipped !== due.clipped)
					report_mismatch("clipped", res_ch.clipped, due.clipped);
			end
			results_checked++;
			if (res_ch.clipped === 1'b1)
				clipped_seen++;
		end
	end

	// result receiver: stall patterns that change now and then, plus a long hold on demand
	ready_mode_t rdy_mode = RDY_ALWAYS;
	int mode_left;
	int hold_left;
	int hold_started;
	int beat;

	always @(posedge clk) begin
		beat <= beat + 1;
		if (hold_started != hold_requests) begin
			hold_started <= hold_requests;
			hold_left    <= LONG_HOLD;
			res_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left    <= hold_left - 1;
			res_ch.ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rdy_mode  <= ready_mode_t'($urandom_range(0, 3));
				mode_left <= $urandom_range(20, 200);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (rdy_mode)
				RDY_ALWAYS: res_ch.ready <= 1'b1;
				RDY_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
				RDY_SPARSE: res_ch.ready <= (beat % 4 == 0);
				default:    res_ch.ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("run stopped at the cycle limit with %0d results pending", expected_q.size());
			$display("testbench NOT OK");
			$finish;
		end
	end

	// stimulus
	initial begin : stimulus
		stim_row_t plan[$];
		coef_style_t schedule[8];
		coef_style_t style;
		int b[3];
		int a[2];
		int span;
		logic [DATA_BITS-1:0] word;
		logic signed [SAMPLE_BITS-1:0] s;

		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= '0;
		cfg_data         <= '0;
		smp_ch.valid     <= 1'b0;
		smp_ch.sample_in <= '0;

		// shadow state after reset
		filt_on = 1'b0;
		num1 = '0;
		num2 = '0;
		den1 = '0;
		den2 = '0;
		stage1_dly = '{0, 0};
		stage2_dly = '{0, 0};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		plan = '{
			// bypass after reset
			sample_row(16'sh8000, 1'b1, 16'sh8000, 1'b0),
			sample_row(16'sh7FFF, 1'b1, 16'sh7FFF, 1'b0),
			sample_row(16'sh0000, 1'b1, 16'sh0000, 1'b0),
			sample_row(-16'sd1, 1'b1, -16'sd1, 1'b0),
			// enable with every bit of the data set, coefficients still zero
			reg_row(bqc_pkg::REG_ENABLE, {DATA_BITS{1'b1}}),
			sample_row(16'sh7FFF, 1'b1, 16'sh0000, 1'b0),
			// unity b0 in both sections, then a write to an unused index
			reg_row(bqc_pkg::REG_NUM1, pack_num(UNITY, 0, 0)),
			reg_row(bqc_pkg::REG_NUM2, pack_num(UNITY, 0, 0)),
			reg_row(REG_VOID, {DATA_BITS{1'b1}}),
			sample_row(16'sh8000, 1'b1, 16'sh8000, 1'b0),
			sample_row(16'sh7FFF, 1'b1, 16'sh7FFF, 1'b0),
			sample_row(16'sd12345, 1'b1, 16'sd12345, 1'b0),
			sample_row(-16'sd1, 1'b1, -16'sd1, 1'b0),
			// largest gains of both signs drive the output into saturation
			reg_row(bqc_pkg::REG_NUM1, pack_num(COEF_MAX, 0, 0)),
			reg_row(bqc_pkg::REG_NUM2, pack_num(COEF_MIN, 0, 0)),
			sample_row(16'sh7FFF, 1'b1, 16'sh8000, 1'b1),
			sample_row(16'sh8000, 1'b1, 16'sh7FFF, 1'b1),
			sample_row(16'sh0000, 1'b1, 16'sh0000, 1'b0),
			// unstable feedback runs the delay words into 32-bit saturation
			reg_row(bqc_pkg::REG_DEN1, pack_den(COEF_MIN, COEF_MIN) | {17'h15A5A, 34'h0}),
			reg_row(bqc_pkg::REG_NUM2, pack_num(UNITY, 0, 0)),
			sample_row(16'sh7FFF), sample_row(16'sh7FFF), sample_row(16'sh7FFF),
			sample_row(16'sh7FFF), sample_row(16'sh7FFF), sample_row(16'sh7FFF),
			sample_row(16'sh7FFF), sample_row(16'sh7FFF),
			// zero coefficients drain the state again
			reg_row(bqc_pkg::REG_NUM1, '0),
			reg_row(bqc_pkg::REG_DEN1, '0),
			sample_row(16'sh0000), sample_row(16'sh0000), sample_row(16'sh0000)
		};
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE)
				write_reg(plan[i].idx, plan[i].data);
			else
				offer_row(plan[i]);
		end
		settings_used = 4;

		// random phases, each with its own coefficient setting
		schedule = '{STYLE_STABLE, STYLE_WILD, STYLE_STABLE, STYLE_EXTREME,
			STYLE_STABLE, STYLE_BYPASS, STYLE_STABLE, STYLE_WILD};
		foreach (schedule[ph]) begin
			style = schedule[ph];
			word = DATA_BITS'({$urandom, $urandom});
			word[0] = (style != STYLE_BYPASS);
			write_reg(bqc_pkg::REG_ENABLE, word);
			for (int sec = 0; sec < 2; sec++) begin
				if (style == STYLE_WILD) begin
					foreach (b[k]) b[k] = $urandom;
					foreach (a[k]) a[k] = $urandom;
				end else if (style == STYLE_EXTREME) begin
					foreach (b[k]) b[k] = extreme_coef();
					foreach (a[k]) a[k] = extreme_coef();
				end else begin
					// poles kept inside the unit circle
					foreach (b[k]) b[k] = int'($urandom_range(0, UNITY)) - UNITY / 2;
					a[1] = $urandom_range(0, 14000);
					span = 15000 + a[1];
					a[0] = int'($urandom_range(0, 2 * span)) - span;
				end
				word = DATA_BITS'({$urandom, $urandom});
				write_reg(sec ? bqc_pkg::REG_NUM2 : bqc_pkg::REG_NUM1,
					pack_num(b[0], b[1], b[2]));
				write_reg(sec ? bqc_pkg::REG_DEN2 : bqc_pkg::REG_DEN1,
					pack_den(a[0], a[1]) | {word[CB-1:0], {DB{1'b0}}});
			end
			write_reg(IDX_BITS'($urandom_range(bqc_pkg::REG_DEN2 + 1, REG_VOID)),
				DATA_BITS'({$urandom, $urandom}));
			settings_used++;

			// long output stall while samples keep coming
			if (ph == 2)
				hold_requests++;

			repeat (ITEMS_PER_PHASE) begin
				case ($urandom_range(0, 19))
					0: s = 16'sh7FFF;
					1: s = 16'sh8000;
					2, 3: s = SAMPLE_BITS'(int'($urandom_range(0, 512)) - 256);
					default: s = SAMPLE_BITS'($urandom);
				endcase
				offer_row(sample_row(s));
			end
		end

		// wait for the last results, then a little longer
		smp_ch.valid <= 1'b0;
		while (offered_q.size() + expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d samples under %0d coefficient settings, bypass and saturation",
			samples_taken, settings_used);
		$display("checked %0d results, %0d of them clipped, with one %0d-cycle output stall",
			results_checked, clipped_seen, LONG_HOLD);
		if (mismatches == 0) begin
			$display("testbench OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
